>>> hw/rtl/fprc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fprc_pkg;

    // Parser phases; codes without a member are treated as the hunt.
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_CRC_LO  = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_CRC_BAD = 2'd2,
        ST_LEN_BAD = 2'd3
    } t_status;

    // Request types on the input channel.
    localparam logic REQ_RX_BYTE = 1'b0;
    localparam logic REQ_READ    = 1'b1;

    localparam logic [7:0]  START_BYTE = 8'hA1;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // Payload memory access issued by the parser for one transfer.
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [7:0] rd_addr;
    } t_mem_req;

    // One byte of the reflected CRC-16 (MCRF4XX) update.
    function automatic logic [15:0] crc_step(input logic [7:0] value, input logic [15:0] crc);
        logic [7:0]  b;
        logic [15:0] w;
        b = value ^ crc[7:0];
        b = b ^ (b << 4);
        w = {8'h00, b};
        return {b, crc[15:8]} ^ (w >> 4) ^ (w << 3);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fprc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one received byte or one payload read request per transfer.
interface fprc_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, output req_type, output rx_byte, output read_index,
                    input ready);
    modport sink (input valid, input req_type, input rx_byte, input read_index,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fprc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Output channel: one result per accepted input transfer.
interface fprc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] packet_type;
    logic [7:0] packet_length;
    logic [7:0] read_data;

    modport source (output valid, output status, output packet_type, output packet_length,
                    output read_data, input ready);
    modport sink (input valid, input status, input packet_type, input packet_length,
                  input read_data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fprc_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame parser: phase sequencer, running CRC and frame header registers.
module fprc_parser #(
    parameter int MAX_PAYLOAD = 200
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic            i_req_type,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic [7:0]      i_read_index,
    output fprc_pkg::t_mem_req   o_mem_req,
    output fprc_pkg::t_status    o_status,
    output logic [7:0]           o_packet_type,
    output logic [7:0]           o_packet_length
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    fprc_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_length, n_length;
    logic [15:0]      r_sent_crc, n_sent_crc;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_count, n_count;
    logic [15:0]      crc_next;
    logic             is_rx;

    assign crc_next = fprc_pkg::crc_step(i_rx_byte, r_crc);
    assign is_rx    = i_accept && (i_req_type == fprc_pkg::REQ_RX_BYTE);

    // Next state, memory access and result fields for the current transfer.
    always_comb begin
        n_phase    = r_phase;
        n_type     = r_type;
        n_length   = r_length;
        n_sent_crc = r_sent_crc;
        n_crc      = r_crc;
        n_count    = r_count;
        o_status   = fprc_pkg::ST_NONE;
        o_mem_req  = '0;

        if (i_accept && (i_req_type == fprc_pkg::REQ_READ)) begin
            o_mem_req.rd_en   = (i_read_index < MAX_LEN);
            o_mem_req.rd_addr = i_read_index;
        end

        if (is_rx) begin
            case (r_phase)
                fprc_pkg::PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_crc   = crc_next;
                    n_phase = fprc_pkg::PH_LEN;
                end
                fprc_pkg::PH_LEN: begin
                    if (i_rx_byte <= MAX_LEN) begin
                        n_length = i_rx_byte;
                        n_crc    = crc_next;
                        n_phase  = fprc_pkg::PH_CRC_LO;
                    end else begin
                        n_length = 8'h00;
                        o_status = fprc_pkg::ST_LEN_BAD;
                        n_phase  = fprc_pkg::PH_HUNT;
                    end
                end
                fprc_pkg::PH_CRC_LO: begin
                    n_sent_crc = {8'h00, i_rx_byte};
                    n_phase    = fprc_pkg::PH_CRC_HI;
                end
                fprc_pkg::PH_CRC_HI: begin
                    n_sent_crc = {i_rx_byte, r_sent_crc[7:0]};
                    if (r_length == 8'h00) begin
                        o_status = (n_sent_crc == r_crc) ? fprc_pkg::ST_ACCEPT
                                                         : fprc_pkg::ST_CRC_BAD;
                        n_phase  = fprc_pkg::PH_HUNT;
                    end else begin
                        n_phase = fprc_pkg::PH_PAYLOAD;
                    end
                end
                fprc_pkg::PH_PAYLOAD: begin
                    o_mem_req.wr_en   = (r_count < MAX_LEN);
                    o_mem_req.wr_addr = r_count;
                    o_mem_req.wr_data = i_rx_byte;
                    n_crc             = crc_next;
                    n_count           = r_count + 8'd1;
                    if (n_count >= r_length) begin
                        o_status = (r_sent_crc == crc_next) ? fprc_pkg::ST_ACCEPT
                                                            : fprc_pkg::ST_CRC_BAD;
                        n_phase  = fprc_pkg::PH_HUNT;
                    end
                end
                default: begin
                    n_phase = fprc_pkg::PH_HUNT;
                    if (i_rx_byte == fprc_pkg::START_BYTE) begin
                        n_crc   = fprc_pkg::CRC_INIT;
                        n_count = 8'h00;
                        n_phase = fprc_pkg::PH_TYPE;
                    end
                end
            endcase
        end

        o_packet_type   = n_type;
        o_packet_length = n_length;
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= fprc_pkg::PH_HUNT;
            r_type     <= 8'h00;
            r_length   <= 8'h00;
            r_sent_crc <= 16'h0000;
            r_crc      <= fprc_pkg::CRC_INIT;
            r_count    <= 8'h00;
        end else begin
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_length   <= n_length;
            r_sent_crc <= n_sent_crc;
            r_crc      <= n_crc;
            r_count    <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/fprc_payload_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Payload store: one write port, one registered read port.
module fprc_payload_mem #(
    parameter int DEPTH = 200
) (
    input  wire logic                i_clk,
    input  wire fprc_pkg::t_mem_req  i_req,
    output logic [7:0]               o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rd_data;

    // Write the payload byte at the current position.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
    end

    // Read data is captured only on a read request and held otherwise.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hw/rtl/framed_packet_receiver_crc16_core.sv
`timescale 1ns / 1ps
// A result appears in the cycle after its input transfer is accepted.
// One transfer per cycle unless stalled; the phase update, the byte CRC step
// and the payload memory access all complete in the cycle of acceptance.
// The input is ready whenever the result register is empty or being drained.
// Reset (synchronous, active low) returns the parser to the start-byte hunt
// and empties the result register; the payload memory is not cleared.
`default_nettype none

module framed_packet_receiver_crc16_core #(
    parameter int MAX_PAYLOAD = 200
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fprc_in_if.sink    i_rx,
    fprc_out_if.source o_res
);

    logic               accept;
    fprc_pkg::t_mem_req mem_req;
    fprc_pkg::t_status  status_next;
    logic [7:0]         type_next;
    logic [7:0]         length_next;
    logic [7:0]         mem_rd_data;

    logic               r_valid;
    fprc_pkg::t_status  r_status;
    logic [7:0]         r_type;
    logic [7:0]         r_length;
    logic               r_rd_sel;

    // A new transfer is taken whenever the result register frees up.
    assign i_rx.ready = !r_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    fprc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_req_type      (i_rx.req_type),
        .i_rx_byte       (i_rx.rx_byte),
        .i_read_index    (i_rx.read_index),
        .o_mem_req       (mem_req),
        .o_status        (status_next),
        .o_packet_type   (type_next),
        .o_packet_length (length_next)
    );

    fprc_payload_mem #(
        .DEPTH (MAX_PAYLOAD)
    ) u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    // Result payload, loaded together with the memory read data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= status_next;
            r_type   <= type_next;
            r_length <= length_next;
            r_rd_sel <= mem_req.rd_en;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.status        = r_status;
    assign o_res.packet_type   = r_type;
    assign o_res.packet_length = r_length;
    assign o_res.read_data     = r_rd_sel ? mem_rd_data : 8'h00;

    // A rejected length always reports a zero packet length.
    a_len_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == fprc_pkg::ST_LEN_BAD)) |-> (r_length == 8'h00))
        else $error("length rejection with nonzero packet length");

    // Read data is only ever returned alongside a neutral status.
    a_read_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_rd_sel) |-> (r_status == fprc_pkg::ST_NONE))
        else $error("read result carries a frame status");

    // The reported length never exceeds the payload store.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_length <= 8'(MAX_PAYLOAD)))
        else $error("packet length above maximum payload");

    // An accepted transfer always produces a result in the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid)
        else $error("accepted transfer produced no result");

endmodule

`default_nettype wire
